// ===== design/bsi_pkg.sv =====
// ----------------------------------------------------------------------------
// bsi_pkg: shared constants for the broadcast source index unit
// Register indexes and widths of the configuration port.
// ----------------------------------------------------------------------------
package bsi_pkg;

	localparam int CFG_IDX_BITS = 8;
	localparam int CFG_DATA_BITS = 64;
	localparam int RANK_BITS = 3;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

	localparam cfg_idx_t REG_OUT_DIMS = 8'd0;
	localparam cfg_idx_t REG_IN_DIMS = 8'd1;
	localparam cfg_idx_t REG_OUT_RANK = 8'd2;
	localparam cfg_idx_t REG_IN_RANK = 8'd3;

endpackage

// ===== design/bsi_ifs.sv =====
// ----------------------------------------------------------------------------
// bsi_ifs: channel interfaces of the broadcast source index unit
// Index input, result output and configuration write channel.
// ----------------------------------------------------------------------------
interface bsi_in_if #(parameter int INDEX_BITS = 32);
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] out_index;
	modport source (output valid, output out_index, input ready);
	modport sink (input valid, input out_index, output ready);
endinterface

interface bsi_out_if #(parameter int INDEX_BITS = 32);
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] src_index;
	logic                  out_of_range;
	logic                  shape_mismatch;
	modport source (output valid, output src_index, output out_of_range,
		output shape_mismatch, input ready);
	modport sink (input valid, input src_index, input out_of_range,
		input shape_mismatch, output ready);
endinterface

interface bsi_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [bsi_pkg::CFG_IDX_BITS-1:0]  index;
	logic [bsi_pkg::CFG_DATA_BITS-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/bsi_cell.sv =====
// ----------------------------------------------------------------------------
// bsi_cell: one restoring division step of the index chain
// The last cell of a dimension also folds the coordinate into the source index.
// ----------------------------------------------------------------------------
module bsi_cell #(
	parameter int DIM_BITS = 16,
	parameter int INDEX_BITS = 32,
	parameter bit LAST = 1'b0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [DIM_BITS-1:0]   od,
	input  logic [DIM_BITS-1:0]   id,
	input  logic                  vld_i,
	input  logic [INDEX_BITS-1:0] num_i,
	input  logic [DIM_BITS-1:0]   rem_i,
	input  logic [INDEX_BITS-1:0] src_i,
	input  logic [INDEX_BITS-1:0] istr_i,
	output logic                  vld_o,
	output logic [INDEX_BITS-1:0] num_o,
	output logic [DIM_BITS-1:0]   rem_o,
	output logic [INDEX_BITS-1:0] src_o,
	output logic [INDEX_BITS-1:0] istr_o
);
	import bsi_pkg::*;

	logic [DIM_BITS:0]            trial;
	logic                         ge;
	logic [DIM_BITS:0]            rem_n;
	logic [INDEX_BITS-1:0]        num_n;
	logic [DIM_BITS-1:0]          coord;
	logic [INDEX_BITS+DIM_BITS-1:0] prod_src;
	logic [INDEX_BITS+DIM_BITS-1:0] prod_str;
	logic [INDEX_BITS-1:0]        src_n;
	logic [INDEX_BITS-1:0]        istr_n;
	logic [DIM_BITS-1:0]          rem_next;

	logic                  vld_q;
	logic [INDEX_BITS-1:0] num_q;
	logic [DIM_BITS-1:0]   rem_q;
	logic [INDEX_BITS-1:0] src_q;
	logic [INDEX_BITS-1:0] istr_q;

	always_comb begin
		trial = {rem_i, num_i[INDEX_BITS-1]};
		ge = (trial >= {1'b0, od});
		rem_n = ge ? (trial - {1'b0, od}) : trial;
		num_n = {num_i[INDEX_BITS-2:0], ge};
		// a size-1 input dimension always reads coordinate 0
		coord = (id == DIM_BITS'(1)) ? '0 : rem_n[DIM_BITS-1:0];
		prod_src = {{INDEX_BITS{1'b0}}, coord} * {{DIM_BITS{1'b0}}, istr_i};
		prod_str = {{INDEX_BITS{1'b0}}, id} * {{DIM_BITS{1'b0}}, istr_i};
		if (LAST) begin
			src_n = src_i + prod_src[INDEX_BITS-1:0];
			istr_n = prod_str[INDEX_BITS-1:0];
			rem_next = '0;
		end else begin
			src_n = src_i;
			istr_n = istr_i;
			rem_next = rem_n[DIM_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_q <= num_n;
			rem_q <= rem_next;
			src_q <= src_n;
			istr_q <= istr_n;
		end
	end

	assign vld_o = vld_q;
	assign num_o = num_q;
	assign rem_o = rem_q;
	assign src_o = src_q;
	assign istr_o = istr_q;

endmodule

// ===== design/broadcast_source_index_unit.sv =====
// ----------------------------------------------------------------------------
// broadcast_source_index_unit: source address generator for a broadcast copy
// Maps a row-major output index to the row-major index of its input element.
// ----------------------------------------------------------------------------
//  channel   dir  transaction carries
//  items     in   out_index
//  results   out  src_index, out_of_range, shape_mismatch
//  cfg       in   index, data (register write, always ready)
//
//  One transaction in and one out per cycle while results does not stall. The
//  result comes from a chain of cells: one restoring division bit per cell,
//  INDEX_BITS cells per dimension, innermost dimension first.
//  Reset clears the configuration to a scalar shape and empties the chain.
//  A stall on results freezes the whole chain; items is ready whenever the
//  final cell is empty or being drained.
// ----------------------------------------------------------------------------
module broadcast_source_index_unit #(
	parameter int MAX_RANK = 4,
	parameter int DIM_BITS = 16,
	parameter int INDEX_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	bsi_in_if.sink        items,
	bsi_out_if.source     results,
	bsi_cfg_if.sink       cfg
);
	import bsi_pkg::*;

	localparam int NCELL = MAX_RANK * INDEX_BITS;

	// configuration registers
	logic [CFG_DATA_BITS-1:0] out_dims_q;
	logic [CFG_DATA_BITS-1:0] in_dims_q;
	logic [RANK_BITS-1:0]     out_rank_q;
	logic [RANK_BITS-1:0]     in_rank_q;

	logic [3:0] orank_c;
	logic [3:0] irank_c;

	logic [DIM_BITS-1:0] od_a [MAX_RANK];
	logic [DIM_BITS-1:0] id_a [MAX_RANK];
	logic [MAX_RANK-1:0] mm_a;
	logic [MAX_RANK-1:0] zero_a;

	// chain taps: index 0 is the incoming transaction
	logic                  vld_c  [NCELL+1];
	logic [INDEX_BITS-1:0] num_c  [NCELL+1];
	logic [DIM_BITS-1:0]   rem_c  [NCELL+1];
	logic [INDEX_BITS-1:0] src_c  [NCELL+1];
	logic [INDEX_BITS-1:0] istr_c [NCELL+1];

	logic en;
	logic oor;
	logic mm;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_dims_q <= '0;
			in_dims_q <= '0;
			out_rank_q <= '0;
			in_rank_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_OUT_DIMS: out_dims_q <= cfg.data;
				REG_IN_DIMS:  in_dims_q <= cfg.data;
				REG_OUT_RANK: out_rank_q <= cfg.data[RANK_BITS-1:0];
				REG_IN_RANK:  in_rank_q <= cfg.data[RANK_BITS-1:0];
				default: ;
			endcase
		end
	end

	// saturate ranks to the number of cells groups built
	assign orank_c = ({1'b0, out_rank_q} > 4'(MAX_RANK)) ? 4'(MAX_RANK) : {1'b0, out_rank_q};
	assign irank_c = ({1'b0, in_rank_q} > 4'(MAX_RANK)) ? 4'(MAX_RANK) : {1'b0, in_rank_q};

	// per-dimension shape, right-aligned; unused outer dimensions read as 1
	for (genvar s = 0; s < MAX_RANK; s++) begin : g_dim
		localparam int LO = s * DIM_BITS;
		logic [CFG_DATA_BITS-1:0] osh;
		logic [CFG_DATA_BITS-1:0] ish;
		assign osh = out_dims_q >> LO;
		assign ish = in_dims_q >> LO;
		assign od_a[s] = (4'(s) < orank_c) ? osh[DIM_BITS-1:0] : DIM_BITS'(1);
		assign id_a[s] = (4'(s) < irank_c) ? ish[DIM_BITS-1:0] : DIM_BITS'(1);
		assign mm_a[s] = (4'(s) < irank_c) && (id_a[s] != DIM_BITS'(1))
			&& (id_a[s] != od_a[s]);
		assign zero_a[s] = (od_a[s] == '0);
	end

	// advance the chain unless the final result is held back
	assign en = !vld_c[NCELL] || results.ready;
	assign items.ready = en;

	assign vld_c[0] = items.valid;
	assign num_c[0] = items.out_index;
	assign rem_c[0] = '0;
	assign src_c[0] = '0;
	assign istr_c[0] = INDEX_BITS'(1);

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		localparam int SLOT = k / INDEX_BITS;
		localparam bit IS_LAST = ((k % INDEX_BITS) == (INDEX_BITS - 1));
		bsi_cell #(
			.DIM_BITS  (DIM_BITS),
			.INDEX_BITS(INDEX_BITS),
			.LAST      (IS_LAST)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.od    (od_a[SLOT]),
			.id    (id_a[SLOT]),
			.vld_i (vld_c[k]),
			.num_i (num_c[k]),
			.rem_i (rem_c[k]),
			.src_i (src_c[k]),
			.istr_i(istr_c[k]),
			.vld_o (vld_c[k+1]),
			.num_o (num_c[k+1]),
			.rem_o (rem_c[k+1]),
			.src_o (src_c[k+1]),
			.istr_o(istr_c[k+1])
		);
	end

	// the index is in range exactly when nothing is left after the last
	// division and no output dimension is zero
	assign mm = |mm_a;
	assign oor = (|zero_a) || (num_c[NCELL] != '0);

	assign results.valid = vld_c[NCELL];
	assign results.out_of_range = oor;
	assign results.shape_mismatch = mm;
	assign results.src_index = (oor || mm) ? '0 : src_c[NCELL];

	// a held result must block new transactions
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.ready) |-> !items.ready)
		else $error("items accepted while result stalled");

	// a raised flag zeroes the source index
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && (results.out_of_range || results.shape_mismatch))
		|-> (results.src_index == '0))
		else $error("flagged result carries a source index");

	// an accepted transaction enters the first cell
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready) |=> vld_c[1])
		else $error("accepted transaction lost at chain entry");

endmodule

// ===== dv/tb_broadcast_source_index_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_broadcast_source_index_unit: self-checking bench for the broadcast unit
// Writes shapes through the register port, streams output indices and checks
// every source index and flag against a predictor of the broadcast mapping.
// ----------------------------------------------------------------------------
module tb_broadcast_source_index_unit;
	import bsi_pkg::*;

	localparam int MAX_RANK = 4;
	localparam int DIM_BITS = 16;
	localparam int INDEX_BITS = 32;
	// pipeline depth of the block, used for the final settle
	localparam int LATENCY = MAX_RANK * INDEX_BITS;

	typedef struct packed {
		logic [INDEX_BITS-1:0] src_index;
		logic                  out_of_range;
		logic                  shape_mismatch;
	} src_result_t;

	logic clk;
	logic arst_n;

	bsi_in_if #(.INDEX_BITS(INDEX_BITS)) items_if ();
	bsi_out_if #(.INDEX_BITS(INDEX_BITS)) results_if ();
	bsi_cfg_if cfg_if ();

	broadcast_source_index_unit #(
		.MAX_RANK(MAX_RANK), .DIM_BITS(DIM_BITS), .INDEX_BITS(INDEX_BITS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.items(items_if.sink), .results(results_if.source), .cfg(cfg_if.sink)
	);

	// shadow copy of the shape registers
	logic [63:0] shp_out_dims, shp_in_dims;
	logic [2:0]  shp_out_rank, shp_in_rank;

	src_result_t expected_q[$];
	int  send_idle_pct, recv_idle_pct;
	bit  failed;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int unsigned eff_rank(logic [2:0] r);
		return (r > MAX_RANK) ? MAX_RANK : r;
	endfunction

	function automatic logic [63:0] dim_at(logic [63:0] packed_dims, int s);
		return (packed_dims >> (s * DIM_BITS)) & 64'hFFFF;
	endfunction

	// map an output index to its input element under the current shapes
	function automatic src_result_t broadcast_lookup(logic [INDEX_BITS-1:0] idx);
		int unsigned orank, irank;
		logic [63:0]  od, id, total, rem, stride, coord, src;
		logic [127:0] prod;
		src_result_t  r;
		orank = eff_rank(shp_out_rank);
		irank = eff_rank(shp_in_rank);
		total = 64'd1;
		r = '0;
		for (int s = 0; s < MAX_RANK; s++) begin
			od = (s < orank) ? dim_at(shp_out_dims, s) : 64'd1;
			id = (s < irank) ? dim_at(shp_in_dims, s) : 64'd1;
			prod = total * od;
			total = (prod[127:64] != 0) ? '1 : prod[63:0];
			if (s < irank && id != 1 && id != od)
				r.shape_mismatch = 1'b1;
		end
		r.out_of_range = !(64'(idx) < total);
		if (!r.out_of_range && !r.shape_mismatch) begin
			rem = 64'(idx);
			stride = 64'd1;
			src = 64'd0;
			for (int s = 0; s < MAX_RANK; s++) begin
				od = (s < orank) ? dim_at(shp_out_dims, s) : 64'd1;
				id = (s < irank) ? dim_at(shp_in_dims, s) : 64'd1;
				coord = 64'd0;
				if (od != 0) begin
					coord = rem % od;
					rem = rem / od;
				end
				if (id == 1)
					coord = 64'd0;
				src = src + coord * stride;
				stride = stride * id;
			end
			r.src_index = src[INDEX_BITS-1:0];
		end
		return r;
	endfunction

	// receiver: drop ready at random, then compare each transaction
	always @(negedge clk)
		results_if.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);

	always @(posedge clk) begin
		src_result_t got, want;
		if (results_if.valid && results_if.ready) begin
			got = '{results_if.src_index, results_if.out_of_range,
				results_if.shape_mismatch};
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, actual %h/%b/%b", $time,
					got.src_index, got.out_of_range, got.shape_mismatch);
				failed = 1'b1;
			end else begin
				want = expected_q.pop_front();
				if (got.src_index !== want.src_index)
					$display("%0t: src_index expected %h actual %h", $time,
						want.src_index, got.src_index);
				if (got.out_of_range !== want.out_of_range)
					$display("%0t: out_of_range expected %b actual %b", $time,
						want.out_of_range, got.out_of_range);
				if (got.shape_mismatch !== want.shape_mismatch)
					$display("%0t: shape_mismatch expected %b actual %b", $time,
						want.shape_mismatch, got.shape_mismatch);
				if (got !== want)
					failed = 1'b1;
			end
		end
	end

	// send one index; valid stays high for a following send
	task automatic send_index(logic [INDEX_BITS-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			items_if.valid <= 1'b0;
			@(negedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.out_index <= idx;
		@(posedge clk);
		while (!items_if.ready) @(posedge clk);
		expected_q = {expected_q, broadcast_lookup(idx)};
		@(negedge clk);
	endtask

	// hold until every expected transaction has come back
	task automatic drain();
		items_if.valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
	endtask

	// valid stays high for a following write; the caller drops it
	task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		case (idx)
			REG_OUT_DIMS: shp_out_dims = data;
			REG_IN_DIMS:  shp_in_dims = data;
			REG_OUT_RANK: shp_out_rank = data[2:0];
			REG_IN_RANK:  shp_in_rank = data[2:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_shape(logic [63:0] od, logic [63:0] id, logic [63:0] orank,
			logic [63:0] irank);
		drain();
		write_reg(REG_OUT_DIMS, od);
		write_reg(REG_IN_DIMS, id);
		write_reg(REG_OUT_RANK, orank);
		write_reg(REG_IN_RANK, irank);
		cfg_if.valid <= 1'b0;
	endtask

	// reset shape is a scalar: only index 0 is in range
	task automatic test_scalar_after_reset();
		send_index('0);
		send_index(32'd1);
		send_index('1);
	endtask

	task automatic test_directed_shapes();
		// 2x3x4x5 output from 3x1x5 input, rank bits above 2:0 ignored
		set_shape(64'h0002_0003_0004_0005, 64'hFFFF_0003_0001_0005,
			64'hFFFF_FFFF_FFFF_FFFC, 64'd3);
		send_index(32'd0);
		send_index(32'd7);
		send_index(32'd64);
		send_index(32'd119);
		send_index(32'd120);
		// incompatible input dimension
		set_shape(64'h0002_0003_0004_0005, 64'h0000_0003_0002_0005, 64'd4, 64'd3);
		send_index(32'd5);
		// rank saturates at the maximum
		set_shape(64'h0002_0003_0004_0005, 64'h0002_0001_0004_0001, 64'd7, 64'd7);
		send_index(32'd33);
		send_index(32'd119);
		// input rank above output rank: extra dims must be 1
		set_shape(64'h0000_0000_0003_0004, 64'h0001_0001_0003_0001, 64'd2, 64'd4);
		send_index(32'd11);
		set_shape(64'h0000_0000_0003_0004, 64'h0002_0001_0003_0001, 64'd2, 64'd4);
		send_index(32'd11);
		// zero dimension: nothing is in range
		set_shape(64'h0000_0000_0000_0003, 64'd0, 64'd2, 64'd0);
		send_index(32'd0);
		// element count saturates; every index is in range
		set_shape('1, '1, 64'd4, 64'd4);
		send_index('1);
		send_index(32'hAAAA_5555);
		set_shape('1, 64'h0001_0001_0001_FFFF, 64'd4, 64'd4);
		send_index('1);
		send_index(32'h5555_AAAA);
		send_index(32'd65535);
	endtask

	// mostly broadcast-compatible shapes with small dims, some noise
	task automatic test_random_shapes(int n_items);
		logic [63:0] od, id, total;
		int orank, irank, per_shape, sent;
		sent = 0;
		while (sent < n_items) begin
			orank = $urandom_range(MAX_RANK);
			irank = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(orank);
			od = '0;
			id = '0;
			total = 64'd1;
			for (int s = 0; s < MAX_RANK; s++) begin
				logic [15:0] d, e;
				d = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
				if ($urandom_range(29) == 0) d = 16'd0;
				e = ($urandom_range(2) == 0) ? 16'd1 : d;
				if ($urandom_range(14) == 0) e = 16'($urandom);
				if (s >= orank) e = ($urandom_range(3) == 0) ? 16'($urandom_range(2)) : 16'd1;
				od[s*DIM_BITS +: DIM_BITS] = d;
				id[s*DIM_BITS +: DIM_BITS] = e;
				if (s < orank) total = total * d;
			end
			if ($urandom_range(7) == 0) od = {$urandom, $urandom};
			if ($urandom_range(7) == 0) id = {$urandom, $urandom};
			set_shape(od, id, {$urandom, 29'($urandom), 3'(orank)},
				{$urandom, 29'($urandom), 3'(irank)});
			per_shape = $urandom_range(8, 30);
			for (int i = 0; i < per_shape; i++) begin
				if ($urandom_range(9) == 0 || total == 0 || total > 64'hFFFF_FFFF)
					send_index($urandom);
				else
					send_index(32'($urandom_range(32'(total - 1))));
			end
			sent += per_shape;
		end
	endtask

	initial begin
		failed = 1'b0;
		send_idle_pct = 38;
		recv_idle_pct = 72;
		arst_n = 1'b0;
		items_if.valid = 1'b0;
		items_if.out_index = '0;
		results_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		shp_out_dims = '0;
		shp_in_dims = '0;
		shp_out_rank = '0;
		shp_in_rank = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_scalar_after_reset();
		test_directed_shapes();
		test_random_shapes(200);
		send_idle_pct = 72;
		recv_idle_pct = 38;
		test_random_shapes(200);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_shapes(200);

		drain();
		repeat (LATENCY + 8) @(negedge clk);
		if (!failed && expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
